>>> rtl/mbrc_pkg.sv
`default_nettype none

package mbrc_pkg;

   // maximum frame size in bytes
   localparam int FRAME_BYTES = 256;
   // frame position counters hold up to FRAME_BYTES
   localparam int LEN_W = 9;

   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [7:0]  FC_MEI     = 8'h2B;
   localparam logic [LEN_W-1:0] POS_MAX = {LEN_W{1'b1}};
   localparam logic [15:0] TICKS_MAX  = 16'hFFFF;

   localparam logic [7:0]  UNIT_ADDRESS_RESET  = 8'd1;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ADDRESS   = 3'd1,
      ST_FUNCTION  = 3'd2,
      ST_EXCEPTION = 3'd3,
      ST_TIMEOUT   = 3'd4,
      ST_CRC       = 3'd5,
      ST_OVERRUN   = 3'd6
   } status_type;

   // register index taken from paddr[2]
   typedef enum logic {
      REG_UNIT_ADDRESS  = 1'b0,
      REG_TIMEOUT_TICKS = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  unit_address;
      logic [15:0] timeout_ticks;
   } cfg_type;

   // reflected crc-16, one byte, lsb first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/mbrc_if.sv
`default_nettype none

interface mbrc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] rx_byte;
   logic [6:0] expected_function;

   modport source (output valid, cmd, rx_byte, expected_function, input ready);
   modport sink   (input valid, cmd, rx_byte, expected_function, output ready);
endinterface

interface mbrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] echo_byte;
   logic [7:0] byte_index;
   logic       frame_done;
   logic [2:0] status;
   logic [7:0] exception_code;

   modport source (output valid, echo_byte, byte_index, frame_done, status, exception_code,
                   input ready);
   modport sink   (input valid, echo_byte, byte_index, frame_done, status, exception_code,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/mbrc_csr.sv
`default_nettype none

module mbrc_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready,
   output mbrc_pkg::cfg_type     cfg
);
   import mbrc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          write_en;

   assign reg_sel  = reg_index_type'(paddr[2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_sel)
            REG_UNIT_ADDRESS:  cfg_in.unit_address  = pwdata[7:0];
            REG_TIMEOUT_TICKS: cfg_in.timeout_ticks = pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_UNIT_ADDRESS:  prdata = {24'h000000, cfg_ff.unit_address};
         REG_TIMEOUT_TICKS: prdata = {16'h0000, cfg_ff.timeout_ticks};
         default:           prdata = 32'h00000000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_address  <= UNIT_ADDRESS_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/modbus_rtu_response_checker.sv
// a byte or tick transaction that yields a result shows it on rsp in the cycle after accept
// throughput: one transaction per cycle while rsp is not stalled; crc, header checks and length tracking all settle
//   in the single combinational pass between the request handshake and the result register
// the result register frees itself in the cycle it is taken, so req stays ready under drain
// reset (synchronous, active high): idle, frame state cleared, unit_address 1, timeout 1000
`default_nettype none

module modbus_rtu_response_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   mbrc_req_if.sink         req_chan,
   mbrc_rsp_if.source       rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);
   import mbrc_pkg::*;

   typedef struct packed {
      logic [7:0] echo_byte;
      logic [7:0] byte_index;
      logic       frame_done;
      logic [2:0] status;
      logic [7:0] exception_code;
   } rsp_type;

   // configuration registers
   cfg_type cfg;

   mbrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // frame state
   logic             receiving_ff,     receiving_in;
   logic [LEN_W-1:0] frame_length_ff,  frame_length_in;
   logic [LEN_W-1:0] bytes_left_ff,    bytes_left_in;
   logic             object_mode_ff,   object_mode_in;
   logic [7:0]       objects_left_ff,  objects_left_in;
   logic [LEN_W-1:0] next_len_pos_ff,  next_len_pos_in;
   logic [15:0]      crc_ff,           crc_in;
   logic [15:0]      delayed_ff,       delayed_in;
   logic [7:0]       hdr_addr_ff,      hdr_addr_in;
   logic [7:0]       hdr_func_ff,      hdr_func_in;
   logic [7:0]       hdr_count_ff,     hdr_count_in;
   logic [15:0]      ticks_ff,         ticks_in;
   logic [6:0]       wanted_func_ff,   wanted_func_in;

   // result register
   logic             rsp_valid_ff,     rsp_valid_in;
   rsp_type          rsp_ff,           rsp_in;

   // per-transaction scratch
   logic             req_fire;
   cmd_type          cmd;
   logic [7:0]       rx;
   logic [LEN_W-1:0] idx;
   logic [15:0]      ticks_inc;
   logic [LEN_W:0]   next_pos_sum;
   logic             emit;
   logic             done;
   status_type       st;
   logic [7:0]       exc;

   assign cmd = cmd_type'(req_chan.cmd);
   assign rx  = req_chan.rx_byte;
   assign idx = frame_length_ff;

   // take a new transaction whenever the result slot is empty or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign ticks_inc    = (ticks_ff != TICKS_MAX) ? ticks_ff + 16'd1 : ticks_ff;
   // next object length field: current position plus length byte plus id and length bytes
   assign next_pos_sum = {1'b0, next_len_pos_ff} + {{(LEN_W-7){1'b0}}, rx}
                         + (LEN_W+1)'(2);

   always_comb begin
      receiving_in    = receiving_ff;
      frame_length_in = frame_length_ff;
      bytes_left_in   = bytes_left_ff;
      object_mode_in  = object_mode_ff;
      objects_left_in = objects_left_ff;
      next_len_pos_in = next_len_pos_ff;
      crc_in          = crc_ff;
      delayed_in      = delayed_ff;
      hdr_addr_in     = hdr_addr_ff;
      hdr_func_in     = hdr_func_ff;
      hdr_count_in    = hdr_count_ff;
      ticks_in        = ticks_ff;
      wanted_func_in  = wanted_func_ff;
      emit            = 1'b0;
      done            = 1'b0;
      st              = ST_OK;
      exc             = 8'h00;
      rsp_in          = rsp_ff;

      if (req_fire) begin
         unique case (cmd)
            CMD_START: begin
               // a start while receiving simply abandons the old frame
               receiving_in    = 1'b1;
               wanted_func_in  = req_chan.expected_function;
               frame_length_in = '0;
               bytes_left_in   = LEN_W'(8);
               object_mode_in  = 1'b0;
               objects_left_in = 8'h00;
               next_len_pos_in = '0;
               crc_in          = CRC_INIT;
               delayed_in      = 16'h0000;
               hdr_addr_in     = 8'h00;
               hdr_func_in     = 8'h00;
               hdr_count_in    = 8'h00;
               ticks_in        = 16'h0000;
            end
            CMD_TICK: begin
               if (receiving_ff) begin
                  ticks_in = ticks_inc;
                  if (ticks_inc > cfg.timeout_ticks) begin
                     receiving_in      = 1'b0;
                     emit              = 1'b1;
                     rsp_in.echo_byte  = 8'h00;
                     rsp_in.byte_index = frame_length_ff[7:0];
                     rsp_in.frame_done = 1'b1;
                     rsp_in.status     = ST_TIMEOUT;
                     rsp_in.exception_code = 8'h00;
                  end
               end
            end
            CMD_BYTE: begin
               if (receiving_ff) begin
                  // crc runs two bytes behind so the trailing crc itself is never fed
                  if (idx >= LEN_W'(2)) begin
                     crc_in = crc_feed(crc_ff, delayed_ff[15:8]);
                  end
                  delayed_in = {delayed_ff[7:0], rx};
                  if (idx == LEN_W'(0)) hdr_addr_in  = rx;
                  if (idx == LEN_W'(1)) hdr_func_in  = rx;
                  if (idx == LEN_W'(2)) hdr_count_in = rx;
                  frame_length_in = idx + LEN_W'(1);
                  if (bytes_left_ff != '0) begin
                     bytes_left_in = bytes_left_ff - LEN_W'(1);
                  end

                  if (idx == LEN_W'(4)) begin
                     // header check on the fifth byte
                     priority if (hdr_addr_ff != cfg.unit_address) begin
                        st = ST_ADDRESS;
                     end else if (hdr_func_ff[6:0] != wanted_func_ff) begin
                        st = ST_FUNCTION;
                     end else if (hdr_func_ff[7]) begin
                        st  = ST_EXCEPTION;
                        exc = hdr_count_ff;
                     end else if (hdr_func_ff >= 8'd1 && hdr_func_ff <= 8'd4) begin
                        object_mode_in = 1'b0;
                        bytes_left_in  = {{(LEN_W-8){1'b0}}, hdr_count_ff};
                     end else if (hdr_func_ff == FC_MEI) begin
                        object_mode_in = 1'b1;
                        bytes_left_in  = LEN_W'(3);
                     end else begin
                        st = ST_FUNCTION;
                     end
                  end else if (object_mode_ff) begin
                     // device-id walk: object count at byte index seven, then id/length pairs
                     if (idx == LEN_W'(7)) begin
                        objects_left_in = rx;
                        bytes_left_in   = LEN_W'(2);
                        next_len_pos_in = LEN_W'(9);
                     end else if (objects_left_ff != 8'h00 && idx == next_len_pos_ff) begin
                        bytes_left_in   = {{(LEN_W-8){1'b0}}, rx} + LEN_W'(2);
                        next_len_pos_in = next_pos_sum[LEN_W] ? POS_MAX
                                                              : next_pos_sum[LEN_W-1:0];
                        objects_left_in = objects_left_ff - 8'd1;
                     end
                  end

                  priority if (st != ST_OK) begin
                     done = 1'b1;
                  end else if (bytes_left_in == '0) begin
                     done = 1'b1;
                     // crc goes low byte first on the wire
                     if (crc_in[7:0] != delayed_in[15:8] || crc_in[15:8] != delayed_in[7:0]) begin
                        st = ST_CRC;
                     end
                  end else if (idx >= LEN_W'(FRAME_BYTES - 1)) begin
                     done = 1'b1;
                     st   = ST_OVERRUN;
                  end

                  if (done) begin
                     receiving_in = 1'b0;
                  end
                  emit                  = 1'b1;
                  rsp_in.echo_byte      = rx;
                  rsp_in.byte_index     = idx[7:0];
                  rsp_in.frame_done     = done;
                  rsp_in.status         = st;
                  rsp_in.exception_code = exc;
               end
            end
            CMD_NONE: begin
               receiving_in = receiving_ff;
            end
            default: begin
               receiving_in = receiving_ff;
            end
         endcase
      end
   end

   // result slot: loaded on emit, cleared once taken
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff    <= 1'b0;
         frame_length_ff <= '0;
         bytes_left_ff   <= LEN_W'(8);
         object_mode_ff  <= 1'b0;
         objects_left_ff <= 8'h00;
         next_len_pos_ff <= '0;
         crc_ff          <= CRC_INIT;
         delayed_ff      <= 16'h0000;
         hdr_addr_ff     <= 8'h00;
         hdr_func_ff     <= 8'h00;
         hdr_count_ff    <= 8'h00;
         ticks_ff        <= 16'h0000;
         wanted_func_ff  <= 7'h00;
         rsp_valid_ff    <= 1'b0;
      end else begin
         receiving_ff    <= receiving_in;
         frame_length_ff <= frame_length_in;
         bytes_left_ff   <= bytes_left_in;
         object_mode_ff  <= object_mode_in;
         objects_left_ff <= objects_left_in;
         next_len_pos_ff <= next_len_pos_in;
         crc_ff          <= crc_in;
         delayed_ff      <= delayed_in;
         hdr_addr_ff     <= hdr_addr_in;
         hdr_func_ff     <= hdr_func_in;
         hdr_count_ff    <= hdr_count_in;
         ticks_ff        <= ticks_in;
         wanted_func_ff  <= wanted_func_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.echo_byte      = rsp_ff.echo_byte;
   assign rsp_chan.byte_index     = rsp_ff.byte_index;
   assign rsp_chan.frame_done     = rsp_ff.frame_done;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.exception_code = rsp_ff.exception_code;

endmodule

`default_nettype wire
